FILE: src/dcdm_pkg.sv
// ----------------------------------------------------------------------------
// dcdm_pkg
// Shared types, codes and the seven-segment table for the debounced counter
// and display multiplexer.
// ----------------------------------------------------------------------------
package dcdm_pkg;

   // event kinds carried by an input item
   typedef enum logic [1:0] {
      FUNC_DEBOUNCE = 2'd0,
      FUNC_REFRESH  = 2'd1,
      FUNC_SAMPLE   = 2'd2
   } func_type;

   // display multiplexer phases
   typedef enum logic [1:0] {
      PHASE_HIGH = 2'd0,
      PHASE_LOW  = 2'd1,
      PHASE_LEDS = 2'd2
   } phase_type;

   // one-hot digit enables
   localparam logic [2:0] DIGIT_NONE = 3'b000;
   localparam logic [2:0] DIGIT_HIGH = 3'b001;
   localparam logic [2:0] DIGIT_LOW  = 3'b010;
   localparam logic [2:0] DIGIT_LEDS = 3'b100;

   localparam logic [7:0] THRESHOLD_RESET = 8'd5;
   localparam logic [7:0] HOLD_MAX        = 8'hFF;
   localparam logic [1:0] LEVELS_RELEASED = 2'b11;

   // next debounce state and press events for both buttons
   typedef struct packed {
      logic [7:0] hold0;
      logic [7:0] hold1;
      logic [1:0] stable;
      logic       inc;
      logic       dec;
   } deb_result_type;

   // next display drive and phase
   typedef struct packed {
      logic [7:0] seg;
      logic [2:0] digit;
      logic [1:0] phase;
      logic       update;
   } disp_result_type;

   // active-low seven-segment pattern of one hex digit
   function automatic logic [7:0] hex_pattern(input logic [3:0] nib);
      logic [7:0] pat;
      unique case (nib)
         4'h0: pat = 8'h40;
         4'h1: pat = 8'h79;
         4'h2: pat = 8'h24;
         4'h3: pat = 8'h30;
         4'h4: pat = 8'h19;
         4'h5: pat = 8'h12;
         4'h6: pat = 8'h02;
         4'h7: pat = 8'h78;
         4'h8: pat = 8'h00;
         4'h9: pat = 8'h10;
         4'hA: pat = 8'h08;
         4'hB: pat = 8'h03;
         4'hC: pat = 8'h46;
         4'hD: pat = 8'h21;
         4'hE: pat = 8'h06;
         4'hF: pat = 8'h0E;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

FILE: src/dcdm_debounce.sv
// ----------------------------------------------------------------------------
// dcdm_debounce
// Next hold counts, stable levels and press events for the two buttons on
// one debounce tick.
// ----------------------------------------------------------------------------
module dcdm_debounce (
   input  logic [1:0]              buttons_n,
   input  logic [7:0]              threshold,
   input  logic [7:0]              hold0,
   input  logic [7:0]              hold1,
   input  logic [1:0]              stable,
   output dcdm_pkg::deb_result_type result
);
   import dcdm_pkg::*;

   logic [7:0] hold_cur [2];
   logic [7:0] hold_nxt [2];
   logic [1:0] stable_nxt;
   logic [1:0] fire;

   assign hold_cur[0] = hold0;
   assign hold_cur[1] = hold1;

   // per-button saturating hold counter and press detect
   always_comb begin
      stable_nxt = stable;
      fire       = 2'b00;
      for (int b = 0; b < 2; b++) begin
         if (!buttons_n[b]) begin
            hold_nxt[b] = (hold_cur[b] < HOLD_MAX) ? hold_cur[b] + 8'd1 : hold_cur[b];
            if (hold_nxt[b] >= threshold) begin
               fire[b]       = stable[b];
               stable_nxt[b] = 1'b0;
            end
         end else begin
            hold_nxt[b]   = 8'd0;
            stable_nxt[b] = 1'b1;
         end
      end
   end

   assign result.hold0  = hold_nxt[0];
   assign result.hold1  = hold_nxt[1];
   assign result.stable = stable_nxt;
   assign result.inc    = fire[0];
   assign result.dec    = fire[1];

endmodule

FILE: src/dcdm_display.sv
// ----------------------------------------------------------------------------
// dcdm_display
// Display multiplexer step: picks the byte and digit enable for the current
// phase and gives the phase that follows.
// ----------------------------------------------------------------------------
module dcdm_display (
   input  logic [1:0]                phase,
   input  logic [7:0]                last_sample,
   input  logic [7:0]                count,
   output dcdm_pkg::disp_result_type result
);
   import dcdm_pkg::*;

   // phase decode; the spare phase only returns to the first
   always_comb begin
      result.seg    = 8'd0;
      result.digit  = DIGIT_NONE;
      result.update = 1'b1;
      unique case (phase)
         PHASE_HIGH: begin
            result.seg   = hex_pattern(last_sample[7:4]);
            result.digit = DIGIT_HIGH;
            result.phase = PHASE_LOW;
         end
         PHASE_LOW: begin
            result.seg   = hex_pattern(last_sample[3:0]);
            result.digit = DIGIT_LOW;
            result.phase = PHASE_LEDS;
         end
         PHASE_LEDS: begin
            result.seg   = count;
            result.digit = DIGIT_LEDS;
            result.phase = PHASE_HIGH;
         end
         default: begin
            result.update = 1'b0;
            result.phase  = PHASE_HIGH;
         end
      endcase
   end

endmodule

FILE: src/debounced_counter_display_mux.sv
// ----------------------------------------------------------------------------
// debounced_counter_display_mux
// Debounced up/down counter with a three-phase seven-segment/LED multiplexer
// and a sample-over-count alarm.
// ----------------------------------------------------------------------------
// Each item is one event: a debounce tick, a display refresh tick or a
// converter sample. An item is registered on acceptance, processed by short
// logic against the block state once the output register can take its
// result, and its single result lands in that output register, so one item
// per clock is sustained while the receiver takes results. The input register
// keeps accepting while a result waits, stalling only when both the input
// and output registers are full and the waiting result is not taken. The
// debounce threshold is written through csr_wr_en/csr_wr_data and resets to
// 5; zero behaves like one.
module debounced_counter_display_mux (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   // input items
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [1:0] req_buttons_n,
   input  logic [7:0] req_sample,
   // result items
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_seg_drive,
   output logic [2:0] rsp_digit_enable,
   output logic       rsp_alarm,
   output logic [7:0] rsp_count
);
   import dcdm_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_func_ff;
   logic [1:0] in_buttons_ff;
   logic [7:0] in_sample_ff;

   // output register
   logic       out_valid_ff, out_valid_in;

   // block state
   logic [7:0] threshold_ff;
   logic [7:0] hold0_ff, hold0_in;
   logic [7:0] hold1_ff, hold1_in;
   logic [1:0] stable_ff, stable_in;
   logic [7:0] count_ff, count_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] last_sample_ff, last_sample_in;
   logic       alarm_ff, alarm_in;
   logic [7:0] seg_ff, seg_in;
   logic [2:0] digit_ff, digit_in;

   logic            advance;
   logic            req_take;
   deb_result_type  deb;
   disp_result_type disp;

   // handshake: the held item moves on when the output register frees up
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   dcdm_debounce u_debounce (
      .buttons_n (in_buttons_ff),
      .threshold (threshold_ff),
      .hold0     (hold0_ff),
      .hold1     (hold1_ff),
      .stable    (stable_ff),
      .result    (deb)
   );

   dcdm_display u_display (
      .phase       (phase_ff),
      .last_sample (last_sample_ff),
      .count       (count_ff),
      .result      (disp)
   );

   // next state for the event in the input register
   always_comb begin
      hold0_in       = hold0_ff;
      hold1_in       = hold1_ff;
      stable_in      = stable_ff;
      count_in       = count_ff;
      phase_in       = phase_ff;
      last_sample_in = last_sample_ff;
      alarm_in       = alarm_ff;
      seg_in         = seg_ff;
      digit_in       = digit_ff;
      if (advance) begin
         unique case (in_func_ff)
            FUNC_DEBOUNCE: begin
               hold0_in  = deb.hold0;
               hold1_in  = deb.hold1;
               stable_in = deb.stable;
               count_in  = count_ff + {7'd0, deb.inc} - {7'd0, deb.dec};
            end
            FUNC_REFRESH: begin
               phase_in = disp.phase;
               if (disp.update) begin
                  seg_in   = disp.seg;
                  digit_in = disp.digit;
               end
            end
            FUNC_SAMPLE: begin
               last_sample_in = in_sample_ff;
               alarm_in       = in_sample_ff > count_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         threshold_ff   <= THRESHOLD_RESET;
         hold0_ff       <= 8'd0;
         hold1_ff       <= 8'd0;
         stable_ff      <= LEVELS_RELEASED;
         count_ff       <= 8'd0;
         phase_ff       <= PHASE_HIGH;
         last_sample_ff <= 8'd0;
         alarm_ff       <= 1'b0;
         seg_ff         <= 8'd0;
         digit_ff       <= DIGIT_NONE;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         hold0_ff       <= hold0_in;
         hold1_ff       <= hold1_in;
         stable_ff      <= stable_in;
         count_ff       <= count_in;
         phase_ff       <= phase_in;
         last_sample_ff <= last_sample_in;
         alarm_ff       <= alarm_in;
         seg_ff         <= seg_in;
         digit_ff       <= digit_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff    <= req_func;
         in_buttons_ff <= req_buttons_n;
         in_sample_ff  <= req_sample;
      end
   end

   // result payload is the state left by the last processed item
   assign rsp_valid        = out_valid_ff;
   assign rsp_seg_drive    = seg_ff;
   assign rsp_digit_enable = digit_ff;
   assign rsp_alarm        = alarm_ff;
   assign rsp_count        = count_ff;

   // at most one digit is ever enabled
   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(digit_ff))
      else $error("more than one digit enabled");

   // the spare phase is never entered
   a_phase_valid: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("display phase out of range");

   // the counter moves only on debounce ticks
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && in_func_ff == FUNC_DEBOUNCE) |=> $stable(count_ff))
      else $error("counter changed outside a debounce tick");

   // the led phase shows the counter and wraps to the first phase
   a_led_phase: assert property (@(posedge clock) disable iff (reset)
      advance && in_func_ff == FUNC_REFRESH && phase_ff == PHASE_LEDS
      |=> phase_ff == PHASE_HIGH && digit_ff == DIGIT_LEDS
          && seg_ff == $past(count_ff))
      else $error("led phase drive mismatch");

   // a result waiting on a stall is not lost
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff)
      else $error("pending result dropped");

endmodule

FILE: bench/counter_display_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_display_checker
// Watches the item channels of the debounced counter and display multiplexer,
// predicts every result from its own copy of the block state and compares the
// results in order. Hands the failure count and the number of results still
// owed to the testbench top.
// ----------------------------------------------------------------------------
module counter_display_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [1:0] req_buttons_n,
   input  logic [7:0] req_sample,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_seg_drive,
   input  logic [2:0] rsp_digit_enable,
   input  logic       rsp_alarm,
   input  logic [7:0] rsp_count,
   output int         fail_count,
   output int         pending_items
);
   import dcdm_pkg::*;

   // active-low segment codes, digit 0 in the low byte
   localparam logic [15:0][7:0] SEG_CODES = {
      8'h0E, 8'h06, 8'h21, 8'h46, 8'h03, 8'h08, 8'h10, 8'h00,
      8'h78, 8'h02, 8'h12, 8'h19, 8'h30, 8'h24, 8'h79, 8'h40
   };

   typedef struct packed {
      logic [7:0] seg;
      logic [2:0] digit;
      logic       alarm;
      logic [7:0] count;
   } drive_item_type;

   // predicted block state
   logic [7:0] threshold;
   logic [7:0] hold_ticks [2];
   logic [1:0] settled;
   logic [7:0] count_val;
   phase_type  disp_phase;
   logic [7:0] last_smp;
   logic       alarm_flag;
   logic [7:0] seg_latch;
   logic [2:0] digit_latch;

   drive_item_type expected_drives [$];
   int             errors = 0;

   // one button per debounce tick; returns a new press
   task automatic debounce_button(input int b, input logic [1:0] levels,
                                  output logic pressed);
      pressed = 1'b0;
      if (!levels[b]) begin
         if (hold_ticks[b] != HOLD_MAX) hold_ticks[b] = hold_ticks[b] + 8'd1;
         if (hold_ticks[b] >= threshold) begin
            if (settled[b]) pressed = 1'b1;
            settled[b] = 1'b0;
         end
      end else begin
         hold_ticks[b] = 8'd0;
         settled[b]    = 1'b1;
      end
   endtask

   // advance the state by one item and queue the drive it shows
   task automatic predict_event(input logic [1:0] func, input logic [1:0] levels,
                                input logic [7:0] smp);
      logic           up;
      logic           down;
      drive_item_type drv;
      case (func)
         FUNC_DEBOUNCE: begin
            debounce_button(0, levels, up);
            if (up) count_val = count_val + 8'd1;
            debounce_button(1, levels, down);
            if (down) count_val = count_val - 8'd1;
         end
         FUNC_REFRESH: begin
            case (disp_phase)
               PHASE_HIGH: begin
                  seg_latch   = SEG_CODES[last_smp[7:4]];
                  digit_latch = DIGIT_HIGH;
                  disp_phase  = PHASE_LOW;
               end
               PHASE_LOW: begin
                  seg_latch   = SEG_CODES[last_smp[3:0]];
                  digit_latch = DIGIT_LOW;
                  disp_phase  = PHASE_LEDS;
               end
               PHASE_LEDS: begin
                  seg_latch   = count_val;
                  digit_latch = DIGIT_LEDS;
                  disp_phase  = PHASE_HIGH;
               end
               default: disp_phase = PHASE_HIGH;
            endcase
         end
         FUNC_SAMPLE: begin
            last_smp   = smp;
            alarm_flag = (smp > count_val);
         end
         default: ;
      endcase
      drv.seg   = seg_latch;
      drv.digit = digit_latch;
      drv.alarm = alarm_flag;
      drv.count = count_val;
      expected_drives.push_back(drv);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // track the channels at every edge
   always @(posedge clock) begin
      drive_item_type want;
      if (reset) begin
         threshold     = THRESHOLD_RESET;
         hold_ticks[0] = 8'd0;
         hold_ticks[1] = 8'd0;
         settled       = LEVELS_RELEASED;
         count_val     = 8'd0;
         disp_phase    = PHASE_HIGH;
         last_smp      = 8'd0;
         alarm_flag    = 1'b0;
         seg_latch     = 8'd0;
         digit_latch   = DIGIT_NONE;
         expected_drives.delete();
      end else begin
         // results first, an item accepted now cannot show yet
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %h %h %h",
                        $time, rsp_seg_drive, rsp_digit_enable, rsp_alarm, rsp_count);
               errors++;
            end else begin
               want = expected_drives.pop_front();
               check_field("seg_drive", want.seg, rsp_seg_drive);
               check_field("digit_enable", 8'(want.digit), 8'(rsp_digit_enable));
               check_field("alarm", 8'(want.alarm), 8'(rsp_alarm));
               check_field("count", want.count, rsp_count);
            end
         end
         if (csr_wr_en) threshold = csr_wr_data;
         if (req_valid && req_ready) predict_event(req_func, req_buttons_n, req_sample);
      end
      pending_items <= expected_drives.size();
      fail_count    <= errors;
   end

endmodule

FILE: bench/tb_debounced_counter_display_mux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_counter_display_mux
// Drives debounce ticks, refresh ticks and samples into the counter and
// display multiplexer with bursty input and a stalling receiver, steps the
// debounce threshold through its extremes between phases and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module tb_debounced_counter_display_mux;
   import dcdm_pkg::*;

   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         DRAIN_CYCLES = 8;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   // active-low button levels
   localparam logic [1:0] BTN_RELEASED = 2'b11;
   localparam logic [1:0] BTN_INC      = 2'b10;
   localparam logic [1:0] BTN_DEC      = 2'b01;
   localparam logic [1:0] BTN_BOTH     = 2'b00;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_func;
   logic [1:0] req_buttons_n;
   logic [7:0] req_sample;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_seg_drive;
   logic [2:0] rsp_digit_enable;
   logic       rsp_alarm;
   logic [7:0] rsp_count;
   int         fail_count;
   int         pending_items;

   int         burst_left = 0;
   int         sent_items = 0;
   int         stall_tick = 0;
   logic [7:0] cur_threshold = THRESHOLD_RESET;

   always #5 clock = ~clock;

   debounced_counter_display_mux dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_buttons_n    (req_buttons_n),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_drive    (rsp_seg_drive),
      .rsp_digit_enable (rsp_digit_enable),
      .rsp_alarm        (rsp_alarm),
      .rsp_count        (rsp_count)
   );

   counter_display_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_buttons_n    (req_buttons_n),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_drive    (rsp_seg_drive),
      .rsp_digit_enable (rsp_digit_enable),
      .rsp_alarm        (rsp_alarm),
      .rsp_count        (rsp_count),
      .fail_count       (fail_count),
      .pending_items    (pending_items)
   );

   // receiver stalls: always ready, coin flip, sparse, then long stall runs
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_tick[7:6])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_tick[1:0] == 2'd0);
         default: rsp_ready <= (stall_tick[4:3] != 2'd0);
      endcase
   end

   // one item, sent in bursts with random gaps
   task automatic send_event(input logic [1:0] func, input logic [1:0] levels,
                             input logic [7:0] smp);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_func      <= func;
      req_buttons_n <= levels;
      req_sample    <= smp;
      do @(posedge clock); while (!req_ready);
      if (func != FUNC_UNUSED) sent_items++;
   endtask

   // refresh or sample with random content
   task automatic display_event();
      logic [7:0] smp;
      case ($urandom_range(0, 5))
         0: smp = 8'h00;
         1: smp = 8'hFF;
         default: smp = 8'($urandom);
      endcase
      if ($urandom_range(0, 1) == 0) send_event(FUNC_REFRESH, 2'($urandom), smp);
      else send_event(FUNC_SAMPLE, 2'($urandom), smp);
   endtask

   // a held press around the threshold, then a release that may bounce
   task automatic press_sequence();
      logic [1:0] held;
      int         hold_len;
      int         eff;
      eff = (cur_threshold == 8'd0) ? 1 : int'(cur_threshold);
      case ($urandom_range(0, 2))
         0: held = BTN_INC;
         1: held = BTN_DEC;
         default: held = BTN_BOTH;
      endcase
      hold_len = $urandom_range(1, eff + 3);
      for (int i = 0; i < hold_len; i++) begin
         if ($urandom_range(0, 4) == 0) display_event();
         send_event(FUNC_DEBOUNCE, held, 8'($urandom));
      end
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 3) == 0) send_event(FUNC_DEBOUNCE, 2'($urandom), 8'($urandom));
         else send_event(FUNC_DEBOUNCE, BTN_RELEASED, 8'($urandom));
      end
   endtask

   // wait for every result plus the pipeline depth
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] thr, input int n_items);
      int stop;
      int pick;
      wait_idle();
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= thr;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      cur_threshold  = thr;
      stop           = sent_items + n_items;
      // long hold past the hold counter's ceiling
      if (thr >= 8'd200) begin
         repeat (300) send_event(FUNC_DEBOUNCE, BTN_INC, 8'($urandom));
         send_event(FUNC_DEBOUNCE, BTN_RELEASED, 8'($urandom));
      end
      while (sent_items < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) press_sequence();
         else if (pick < 85) display_event();
         else if (pick < 95) send_event(FUNC_DEBOUNCE, 2'($urandom), 8'($urandom));
         else send_event(FUNC_UNUSED, 2'($urandom), 8'($urandom));
      end
   endtask

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL debounced_counter_display_mux");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 8'd0;
      req_valid     = 1'b0;
      req_func      = FUNC_DEBOUNCE;
      req_buttons_n = BTN_RELEASED;
      req_sample    = 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: sample equal to count, all three display phases
      send_event(FUNC_SAMPLE, BTN_RELEASED, 8'h00);
      repeat (3) send_event(FUNC_REFRESH, BTN_RELEASED, 8'h00);
      send_event(FUNC_UNUSED, BTN_BOTH, 8'hFF);
      send_event(FUNC_SAMPLE, BTN_RELEASED, 8'hFF);
      // both buttons at once, increment and decrement cancel
      repeat (5) send_event(FUNC_DEBOUNCE, BTN_BOTH, 8'h00);
      send_event(FUNC_DEBOUNCE, BTN_RELEASED, 8'h00);
      send_event(FUNC_DEBOUNCE, BTN_INC, 8'h00);
      // decrement below zero wraps the counter
      repeat (5) send_event(FUNC_DEBOUNCE, BTN_DEC, 8'h00);
      send_event(FUNC_DEBOUNCE, BTN_RELEASED, 8'h00);
      send_event(FUNC_SAMPLE, BTN_RELEASED, 8'hFF);
      repeat (3) send_event(FUNC_REFRESH, BTN_RELEASED, 8'h00);

      // random phases across thresholds, zero and both ends among them
      run_phase(8'd1, 220);
      run_phase(8'd0, 200);
      run_phase(8'd255, 340);
      run_phase(8'd2, 220);
      run_phase(8'($urandom_range(3, 12)), 220);
      run_phase(THRESHOLD_RESET, 200);
      wait_idle();

      if (fail_count == 0) $display("PASS debounced_counter_display_mux");
      else $display("FAIL debounced_counter_display_mux");
      $finish;
   end

endmodule
